[rtl/core/acd_pkg.sv]
// acd_pkg: shared types and constants for the array change detector
// used by the front end, queue, back end and top level; depends on nothing

`default_nettype none

package acd_pkg;

    localparam int WORD_BYTES  = 8;
    localparam int FIFO_DEPTH  = 4;
    localparam int DIM_PORTS   = 4;
    localparam int SIZE_W      = 16;
    localparam int IN_TDATA_W  = 136;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ELEM_SIZE_LOG2 = 3'd0,
        REG_DIM_COUNT      = 3'd1,
        REG_DIM0_SIZE      = 3'd2,
        REG_DIM1_SIZE      = 3'd3,
        REG_DIM2_SIZE      = 3'd4,
        REG_DIM3_SIZE      = 3'd5
    } acd_reg_t;

    typedef struct packed {
        logic [DIM_PORTS-1:0][SIZE_W-1:0] dim_size;
        logic [2:0]                       dim_count;
        logic [1:0]                       size_log2;
    } acd_cfg_t;

    // one classified word waiting for the back end
    typedef struct packed {
        logic [63:0] old_word;
        logic [63:0] new_word;
        logic [3:0]  count;
        logic [7:0]  change_mask;
        logic        last;
    } acd_item_t;

    function automatic logic [63:0] elem_mask(input logic [1:0] lg);
        logic [63:0] m;
        case (lg)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/core/acd_front.sv]
// acd_front: accepts word pairs and classifies them into changed elements
// depends on acd_pkg

`default_nettype none

module acd_front
    import acd_pkg::*;
(
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic [1:0]            size_log2,
    input  wire logic                  q_full,
    output logic                       q_push,
    output acd_item_t                  q_item
);

    logic [63:0] old_w;
    logic [63:0] new_w;
    logic [3:0]  vb;
    logic [3:0]  vb_sat;
    logic [3:0]  count;
    logic [7:0]  byte_diff;
    logic [7:0]  mask;

    assign old_w = s_tdata[63:0];
    assign new_w = s_tdata[127:64];
    assign vb    = s_tdata[131:128];

    assign vb_sat = (vb > 4'd8) ? 4'd8 : vb;
    assign count  = vb_sat >> size_log2;

    always_comb
    begin
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            byte_diff[b] = (old_w[8*b +: 8] != new_w[8*b +: 8]);
        end
        mask = '0;
        case (size_log2)
            2'd0:
            begin
                mask = byte_diff;
            end
            2'd1:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mask[i] = |byte_diff[2*i +: 2];
                end
            end
            2'd2:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    mask[i] = |byte_diff[4*i +: 4];
                end
            end
            default:
            begin
                mask[0] = |byte_diff;
            end
        endcase
        // drop elements past the valid count
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            if (4'(i) >= count)
            begin
                mask[i] = 1'b0;
            end
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_item.old_word    = old_w;
        q_item.new_word    = new_w;
        q_item.count       = count;
        q_item.change_mask = mask;
        q_item.last        = s_tlast;
    end

endmodule

`default_nettype wire

[rtl/core/acd_fifo.sv]
// acd_fifo: short queue of classified words between front and back end
// depends on acd_pkg

`default_nettype none

module acd_fifo
    import acd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire acd_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output acd_item_t      head,
    output logic           empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    acd_item_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   fill_reg;
    logic [PTR_W:0]   fill_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (fill_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/acd_back.sv]
// acd_back: walks queued words one element per cycle, a changed one waiting for
// a free registered result output; keeps position counters; depends on acd_pkg

`default_nettype none

module acd_back
    import acd_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int INDEX_BITS = 24,
    parameter int OUT_W      = 216
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire acd_cfg_t         cfg,
    input  wire acd_item_t        head,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast
);

    localparam int DIMS  = (MAX_DIMS < DIM_PORTS) ? MAX_DIMS : DIM_PORTS;

    logic [2:0]            elem_reg;
    logic [2:0]            elem_next;
    logic [INDEX_BITS-1:0] flat_reg;
    logic [INDEX_BITS-1:0] flat_next;
    logic [SIZE_W-1:0]     cnt_reg [DIMS];
    logic [SIZE_W-1:0]     cnt_next [DIMS];
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_last_reg;

    logic [2:0]            n_use;
    logic                  has_elem;
    logic                  changed;
    logic                  out_free;
    logic                  step;
    logic                  done;
    logic                  emit;
    logic [2:0]            byte_off;
    logic [5:0]            bit_off;
    logic [63:0]           old_val;
    logic [63:0]           new_val;
    logic                  run_last;
    logic [SIZE_W-1:0]     idx [DIM_PORTS];
    logic                  carry;
    logic [SIZE_W:0]       inc;

    // dimensions in use, clamped to the counters that exist
    always_comb
    begin
        if (cfg.dim_count == 3'd0)
        begin
            n_use = 3'd1;
        end
        else if (cfg.dim_count > 3'(DIMS))
        begin
            n_use = 3'(DIMS);
        end
        else
        begin
            n_use = cfg.dim_count;
        end
    end

    assign has_elem = ({1'b0, elem_reg} < head.count) && !q_empty;
    assign changed  = has_elem && head.change_mask[elem_reg];
    assign out_free = !out_valid_reg || m_tready;
    assign step     = !q_empty && (!changed || out_free);
    assign done     = !has_elem || (({1'b0, elem_reg} + 4'd1) == head.count);
    assign emit     = step && changed;
    assign q_pop    = step && done;

    assign byte_off = elem_reg << cfg.size_log2;
    assign bit_off  = {byte_off, 3'b000};
    assign old_val  = (head.old_word >> bit_off) & elem_mask(cfg.size_log2);
    assign new_val  = (head.new_word >> bit_off) & elem_mask(cfg.size_log2);
    assign run_last = ((head.change_mask >> elem_reg) >> 1) == 8'd0;

    generate
        for (genvar d = 0; d < DIM_PORTS; d++)
        begin : g_idx
            if (d < DIMS)
            begin : g_used
                assign idx[d] = (3'(d) < n_use) ? cnt_reg[d] : '0;
            end
            else
            begin : g_none
                assign idx[d] = '0;
            end
        end
    endgenerate

    // position update: one mixed-radix step per element, last dimension fastest
    always_comb
    begin
        carry     = 1'b1;
        inc       = '0;
        flat_next = flat_reg;
        for (int d = 0; d < DIMS; d++)
        begin
            cnt_next[d] = cnt_reg[d];
        end
        if (step && has_elem)
        begin
            flat_next = flat_reg + {{(INDEX_BITS-1){1'b0}}, 1'b1};
            for (int d = DIMS - 1; d >= 0; d--)
            begin
                if (carry && (3'(d) < n_use))
                begin
                    inc = {1'b0, cnt_reg[d]} + 17'd1;
                    if (inc >= {1'b0, cfg.dim_size[d]})
                    begin
                        cnt_next[d] = '0;
                    end
                    else
                    begin
                        cnt_next[d] = inc[SIZE_W-1:0];
                        carry       = 1'b0;
                    end
                end
            end
        end
        if (q_pop && head.last)
        begin
            flat_next = '0;
            for (int d = 0; d < DIMS; d++)
            begin
                cnt_next[d] = '0;
            end
        end
    end

    always_comb
    begin
        elem_next = elem_reg;
        if (q_pop)
        begin
            elem_next = 3'd0;
        end
        else if (step)
        begin
            elem_next = elem_reg + 3'd1;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg      <= '0;
            flat_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < DIMS; d++)
            begin
                cnt_reg[d] <= '0;
            end
        end
        else
        begin
            elem_reg      <= elem_next;
            flat_reg      <= flat_next;
            out_valid_reg <= out_valid_next;
            for (int d = 0; d < DIMS; d++)
            begin
                cnt_reg[d] <= cnt_next[d];
            end
        end
    end

    // fields packed from the lowest bit up, zero padded to whole bytes
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= OUT_W'({new_val, old_val,
                                    idx[3], idx[2], idx[1], idx[0], flat_reg});
            out_last_reg <= run_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/core/array_change_detector_unit.sv]
// array_change_detector_unit: top level with configuration registers,
// front classifier, word queue and back end; depends on acd_pkg and submodules

// Compares an old and a new copy of an array streamed as 64-bit little-endian
// word pairs and reports every element (1, 2, 4 or 8 bytes) whose value
// differs, in ascending order, with its flat index, its per-dimension indices
// and both values. The front end classifies a word in the cycle it is
// accepted and pushes it into a 4-entry queue; the back end then walks the
// word one element per cycle, a changed element waiting for a free output
// register, and pops a word with no whole element without a position step. The
// back end's position counter steps once per element. A result waits in an
// output register; while it is stalled the back end keeps skipping unchanged
// elements and the queue keeps absorbing new words. The input is held off
// only while the queue holds four words. Position counters clear once the
// word marked tlast has been walked. Configuration writes are always taken
// and must only be issued while the block is idle.

`default_nettype none

module array_change_detector_unit
    import acd_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int INDEX_BITS = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input word pairs
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // old_word [63:0], new_word [127:64], valid_bytes [131:128], zero pad
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    // last_word
    input  wire logic                  s_tlast,
    // changed elements
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // element_index, index_dim0, index_dim1, index_dim2, index_dim3,
    // old_value, new_value, zero pad
    output logic [((INDEX_BITS+192+7)/8)*8-1:0] m_tdata,
    // last_of_run
    output logic                       m_tlast,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_addr,
    input  wire logic [15:0]           cfg_data
);

    localparam int OUT_W = ((INDEX_BITS + 192 + 7) / 8) * 8;

    acd_cfg_t  cfg_reg;
    acd_cfg_t  cfg_next;
    acd_item_t push_item;
    acd_item_t head;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;

    // configuration registers, one transaction per cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (acd_reg_t'(cfg_addr))
                REG_ELEM_SIZE_LOG2: cfg_next.size_log2   = cfg_data[1:0];
                REG_DIM_COUNT:      cfg_next.dim_count   = cfg_data[2:0];
                REG_DIM0_SIZE:      cfg_next.dim_size[0] = cfg_data;
                REG_DIM1_SIZE:      cfg_next.dim_size[1] = cfg_data;
                REG_DIM2_SIZE:      cfg_next.dim_size[2] = cfg_data;
                REG_DIM3_SIZE:      cfg_next.dim_size[3] = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_log2 <= 2'd0;
            cfg_reg.dim_count <= 3'd1;
            for (int d = 0; d < DIM_PORTS; d++)
            begin
                cfg_reg.dim_size[d] <= 16'd1;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: per-element change mask and element count
    acd_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .size_log2 (cfg_reg.size_log2),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // decoupling queue
    acd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty)
    );

    // back end: element walk, position counters, result register
    acd_back #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS),
        .OUT_W      (OUT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/core/acd_checker.sv]
// acd_checker: port-level assertions for array_change_detector_unit
// bound to the top level; depends only on the top level's ports

`default_nettype none

module acd_checker
#(
    parameter int INDEX_BITS = 24
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [((INDEX_BITS+192+7)/8)*8-1:0] m_tdata,
    input wire logic                  m_tlast,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // only changed elements are reported
    a_values_differ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[INDEX_BITS+64 +: 64] != m_tdata[INDEX_BITS+128 +: 64])
        else $error("reported element has equal old and new values");

    // configuration transactions are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // handshake outputs are always driven out of reset
    a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tready, m_tvalid, cfg_ready}))
        else $error("handshake output unknown");

endmodule

bind array_change_detector_unit acd_checker #(.INDEX_BITS(INDEX_BITS)) u_acd_checker (.*);

`default_nettype wire

[tb/acd_change_monitor.sv]
// acd_change_monitor: watches the word, change and configuration channels of the
// array change detector, predicts every changed element and compares it
// depends on acd_pkg for the register indexes and the input tdata width

module acd_change_monitor
    import acd_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int INDEX_BITS = 24,
    parameter int OUT_W      = 216
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // old_word, new_word, valid_bytes, zero pad
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // last_word
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // element_index, index_dim0..index_dim3, old_value, new_value
    input  logic [OUT_W-1:0]      m_tdata,
    // last_of_run
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [2:0]            cfg_addr,
    input  logic [15:0]           cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    changes_checked
);

    typedef struct packed {
        logic [INDEX_BITS-1:0] element_index;
        logic [3:0][15:0]      dim_index;
        logic [63:0]           old_value;
        logic [63:0]           new_value;
        logic                  last_of_run;
    } change_t;

    change_t predicted_changes[$];
    change_t want;

    // predictor copy of the registers and the position counters
    logic [1:0]            size_log2;
    logic [2:0]            dim_count;
    logic [15:0]           dim_size [4];
    logic [INDEX_BITS-1:0] flat_pos;
    logic [15:0]           dim_pos [4];

    function automatic int dims_used();
        int n;
        n = dim_count;
        if (n < 1) n = 1;
        if (n > MAX_DIMS) n = MAX_DIMS;
        if (n > 4) n = 4;
        return n;
    endfunction

    task automatic clear_position();
        int d;
        flat_pos = '0;
        for (d = 0; d < 4; d++) dim_pos[d] = 16'd0;
    endtask

    // mixed-radix increment, last used dimension fastest
    task automatic step_position(input int used);
        int d;
        logic [16:0] bumped;
        logic carry;
        flat_pos = flat_pos + 1'b1;
        carry = 1'b1;
        for (d = used - 1; d >= 0; d--) begin
            if (carry) begin
                bumped = {1'b0, dim_pos[d]} + 17'd1;
                if (bumped >= {1'b0, dim_size[d]}) begin
                    dim_pos[d] = 16'd0;
                end
                else begin
                    dim_pos[d] = bumped[15:0];
                    carry = 1'b0;
                end
            end
        end
    endtask

    task automatic find_changes(input logic [63:0] old_w, input logic [63:0] new_w,
                                input logic [3:0] vb_raw, input logic last_w);
        int          vb;
        int          count;
        int          width;
        int          used;
        int          i;
        int          n_found;
        logic [63:0] emask;
        logic [63:0] ov;
        logic [63:0] nv;
        change_t     entry;
        change_t     found [8];
        vb = (vb_raw > 4'd8) ? 8 : vb_raw;
        count = vb >> size_log2;
        width = 8 << size_log2;
        emask = (width == 64) ? {64{1'b1}} : ((64'd1 << width) - 64'd1);
        used = dims_used();
        n_found = 0;
        for (i = 0; i < count; i++) begin
            ov = (old_w >> (i * width)) & emask;
            nv = (new_w >> (i * width)) & emask;
            if (ov != nv) begin
                entry.element_index = flat_pos;
                entry.dim_index[0]  = dim_pos[0];
                entry.dim_index[1]  = (used > 1) ? dim_pos[1] : 16'd0;
                entry.dim_index[2]  = (used > 2) ? dim_pos[2] : 16'd0;
                entry.dim_index[3]  = (used > 3) ? dim_pos[3] : 16'd0;
                entry.old_value     = ov;
                entry.new_value     = nv;
                entry.last_of_run   = 1'b0;
                found[n_found] = entry;
                n_found++;
            end
            step_position(used);
        end
        if (n_found > 0) begin
            entry = found[n_found - 1];
            entry.last_of_run = 1'b1;
            found[n_found - 1] = entry;
        end
        for (i = 0; i < n_found; i++) predicted_changes.push_back(found[i]);
        if (last_w) clear_position();
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            size_log2 = 2'd0;
            dim_count = 3'd1;
            for (int d = 0; d < 4; d++) dim_size[d] = 16'd1;
            clear_position();
            predicted_changes.delete();
            mismatches = 0;
            changes_checked = 0;
            pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_ELEM_SIZE_LOG2: size_log2 = cfg_data[1:0];
                    REG_DIM_COUNT:      dim_count = cfg_data[2:0];
                    REG_DIM0_SIZE:      dim_size[0] = cfg_data;
                    REG_DIM1_SIZE:      dim_size[1] = cfg_data;
                    REG_DIM2_SIZE:      dim_size[2] = cfg_data;
                    REG_DIM3_SIZE:      dim_size[3] = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                find_changes(s_tdata[63:0], s_tdata[127:64], s_tdata[131:128], s_tlast);
            if (m_tvalid && m_tready) begin
                if (predicted_changes.size() == 0) begin
                    $error("change with nothing predicted: element_index 'h%0h",
                           m_tdata[INDEX_BITS-1:0]);
                    mismatches++;
                end
                else begin
                    want = predicted_changes.pop_front();
                    check_field("element_index", want.element_index,
                                m_tdata[INDEX_BITS-1:0]);
                    check_field("index_dim0", want.dim_index[0], m_tdata[INDEX_BITS +: 16]);
                    check_field("index_dim1", want.dim_index[1],
                                m_tdata[INDEX_BITS+16 +: 16]);
                    check_field("index_dim2", want.dim_index[2],
                                m_tdata[INDEX_BITS+32 +: 16]);
                    check_field("index_dim3", want.dim_index[3],
                                m_tdata[INDEX_BITS+48 +: 16]);
                    check_field("old_value", want.old_value, m_tdata[INDEX_BITS+64 +: 64]);
                    check_field("new_value", want.new_value, m_tdata[INDEX_BITS+128 +: 64]);
                    check_field("last_of_run", want.last_of_run, m_tlast);
                    changes_checked++;
                end
            end
            pending = predicted_changes.size();
        end
    end

endmodule

[tb/tb_top.sv]
// tb_top: stimulus and verdict for array_change_detector_unit
// drives word pairs, configuration writes and output backpressure;
// depends on acd_pkg, the block itself and acd_change_monitor

module tb_top;
    import acd_pkg::*;

    localparam int MAX_DIMS     = 4;
    localparam int INDEX_BITS   = 24;
    localparam int OUT_W        = ((INDEX_BITS + 192 + 7) / 8) * 8;
    // watchdog limit for the whole run
    localparam int CYCLE_LIMIT  = 200000;
    // queue of four words, the head being the one walked
    localparam int DRAIN_CYCLES = 64;
    // long output stall, long enough to fill the word queue
    localparam int HOLD_CYCLES  = 120;
    localparam int RANDOM_WORDS = 220;
    // register slots past the last defined register
    localparam logic [2:0] SPARE_ADDR_LO = 3'd6;
    localparam logic [2:0] SPARE_ADDR_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_addr  = 3'd0;
    logic [15:0]           cfg_data  = 16'd0;

    int mismatches;
    int pending;
    int changes_checked;

    // idling controls for the sender and the receiver
    int tx_idle_pct   = 22;
    int rx_idle_pct   = 83;
    bit hold_request  = 1'b0;

    int words_sent    = 0;
    int settings_used = 0;

    // effective settings, used to size well-formed arrays
    int cur_lg   = 0;
    int cur_dims = 1;
    int cur_size [4] = '{1, 1, 1, 1};

    array_change_detector_unit #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    acd_change_monitor #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS),
        .OUT_W      (OUT_W)
    ) change_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .changes_checked (changes_checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog: a stuck handshake or a lost change ends the run here
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top: done, errors");
        $finish;
    end

    // receiver: random backpressure, or one long hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // one configuration transaction; valid stays up for a following write
    task automatic cfg_write(input logic [2:0] addr, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // write all six registers with raw data, upper junk bits included
    task automatic configure(input logic [15:0] lg_data, input logic [15:0] dims_data,
                             input logic [15:0] s0, input logic [15:0] s1,
                             input logic [15:0] s2, input logic [15:0] s3);
        int dims;
        cfg_write(REG_ELEM_SIZE_LOG2, lg_data);
        cfg_write(REG_DIM_COUNT, dims_data);
        cfg_write(REG_DIM0_SIZE, s0);
        cfg_write(REG_DIM1_SIZE, s1);
        cfg_write(REG_DIM2_SIZE, s2);
        cfg_write(REG_DIM3_SIZE, s3);
        @(negedge clk);
        cfg_valid <= 1'b0;
        dims = dims_data[2:0];
        if (dims < 1) dims = 1;
        if (dims > MAX_DIMS) dims = MAX_DIMS;
        if (dims > 4) dims = 4;
        cur_lg      = lg_data[1:0];
        cur_dims    = dims;
        // a zero size behaves like one
        cur_size[0] = (s0 == 16'd0) ? 1 : s0;
        cur_size[1] = (s1 == 16'd0) ? 1 : s1;
        cur_size[2] = (s2 == 16'd0) ? 1 : s2;
        cur_size[3] = (s3 == 16'd0) ? 1 : s3;
        settings_used++;
    endtask

    // stop offering, wait for every predicted change, then let the back end
    // finish walking any unchanged words still queued
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // one word pair transaction, with random gaps ahead of it
    task automatic send_word(input logic [63:0] old_w, input logic [63:0] new_w,
                             input logic [3:0] vb, input logic last_w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, vb, new_w, old_w};
        s_tlast  <= last_w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // flip random bits in roughly pct percent of the elements
    function automatic logic [63:0] mutate_word(input logic [63:0] base, input int lg,
                                                input int pct);
        int          k;
        int          width;
        logic [63:0] emask;
        logic [63:0] flip;
        logic [63:0] result;
        width = 8 << lg;
        emask = (width == 64) ? {64{1'b1}} : ((64'd1 << width) - 64'd1);
        result = base;
        for (k = 0; k < (8 >> lg); k++)
        begin
            if ($urandom_range(0, 99) < pct)
            begin
                flip = {$urandom, $urandom} & emask;
                if (flip == 64'd0) flip = 64'd1;
                result = result ^ (flip << (k * width));
            end
        end
        return result;
    endfunction

    // whole array under the current settings, tlast on its final word;
    // bytes past the end of the final word carry random junk
    task automatic send_array(input int pct);
        int          elems;
        int          bytes_left;
        int          vb;
        int          d;
        logic [63:0] old_w;
        elems = 1;
        for (d = 0; d < cur_dims; d++) elems = elems * cur_size[d];
        bytes_left = elems << cur_lg;
        while (bytes_left > 0)
        begin
            vb = (bytes_left > 8) ? 8 : bytes_left;
            old_w = {$urandom, $urandom};
            send_word(old_w, mutate_word(old_w, cur_lg, pct), 4'(vb), bytes_left <= 8);
            bytes_left -= vb;
        end
    endtask

    initial
    begin
        int          mode;
        int          goal;
        int          dims;
        int          lim;
        int          d;
        logic [15:0] sz [4];
        logic [63:0] w;

        // reset held, then released on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // ---------------- directed part ----------------

        // reset settings: bytes, one dimension of size one
        send_word(64'h0, 64'hFF, 4'd8, 1'b1);
        drain();

        // bytes, one dimension at the largest size, all sizes at their top
        configure(16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(64'h0, {64{1'b1}}, 4'd8, 1'b0);      // every byte changes
        w = {$urandom, $urandom};
        send_word(w, w, 4'd8, 1'b0);                   // nothing changes
        w = {$urandom, $urandom};
        send_word(w, ~w, 4'd0, 1'b0);                  // no valid bytes
        send_word(w, ~w, 4'd15, 1'b0);                 // valid_bytes above eight
        send_word({64{1'b1}}, 64'h0, 4'd3, 1'b1);      // short last word
        drain();

        // halfwords with junk above the size field, dim count zero, size zero
        configure(16'hFFFD, 16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF);
        w = {$urandom, $urandom};
        send_word(w, ~w, 4'd7, 1'b0);                  // stray byte after 3 elements
        send_word(w, ~w, 4'd1, 1'b0);                  // less than one element
        send_word(w, mutate_word(w, 1, 50), 4'd8, 1'b1);
        drain();

        // words, dim count seven clamps to four
        configure(16'h0002, 16'h0007, 16'd2, 16'd3, 16'd1, 16'd2);
        send_array(70);
        drain();

        // doublewords, dim count five, every size zero
        configure(16'h0003, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_word(64'h0, {64{1'b1}}, 4'd8, 1'b0);
        send_word({64{1'b1}}, 64'h0, 4'd8, 1'b0);
        send_word({$urandom, $urandom}, {$urandom, $urandom}, 4'd8, 1'b1);
        drain();

        // counter left above a size that then shrinks; spare slots written too
        cfg_write(SPARE_ADDR_LO, 16'($urandom));
        cfg_write(SPARE_ADDR_HI, 16'($urandom));
        configure(16'h0000, 16'h0002, 16'd1, 16'd8, 16'd1, 16'd1);
        w = {$urandom, $urandom};
        send_word(w, ~w, 4'd6, 1'b0);                  // inner counter ends at six
        drain();
        configure(16'h0000, 16'h0002, 16'd1, 16'd4, 16'd1, 16'd1);
        send_word(w, ~w, 4'd8, 1'b1);                  // counter above its new size
        drain();

        // ---------------- random part ----------------

        // mode 0: slow receiver, mode 1: slow sender, mode 2: no idling
        for (mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 83 : 0;
            rx_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 22 : 0;
            goal = words_sent + RANDOM_WORDS / 3;
            if (mode == 2)
            begin
                // long output hold-off while a dense array keeps coming
                drain();
                configure(16'h0000, 16'h0001, 16'd64, 16'd1, 16'd1, 16'd1);
                hold_request = 1'b1;
                send_array(100);
            end
            while (words_sent < goal)
            begin
                drain();
                // raw dim count over its full field, small used sizes,
                // unused sizes anywhere in their range
                dims = $urandom_range(0, 7);
                lim = (dims <= 1) ? 40 : (dims == 2) ? 8 : (dims == 3) ? 4 : 3;
                for (d = 0; d < 4; d++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        sz[d] = 16'd0;
                    else if (d >= dims && dims > 0)
                        sz[d] = 16'($urandom);
                    else
                        sz[d] = 16'($urandom_range(1, lim));
                end
                configure({14'($urandom), 2'($urandom_range(0, 3))},
                          {13'($urandom), 3'(dims)}, sz[0], sz[1], sz[2], sz[3]);
                repeat ($urandom_range(2, 4))
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        // noise: any valid_bytes, stray tlast
                        w = {$urandom, $urandom};
                        send_word(w,
                                  $urandom_range(0, 1) ? {$urandom, $urandom}
                                                       : mutate_word(w, cur_lg, 50),
                                  4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0);
                    end
                    else
                    begin
                        send_array($urandom_range(0, 60));
                    end
                end
            end
        end

        drain();

        $display("tb_top: %0d words over %0d settings, %0d changed elements compared",
                 words_sent, settings_used, changes_checked);
        $display("tb_top: element widths 1-8 bytes, 1-4 dims, partial and empty words, stalls");
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/acd_pkg.sv
rtl/core/acd_front.sv
rtl/core/acd_fifo.sv
rtl/core/acd_back.sv
rtl/core/array_change_detector_unit.sv
rtl/core/acd_checker.sv
tb/acd_change_monitor.sv
tb/tb_top.sv
